FILE: sv/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg: shared types and constants for the circle segment distance unit
// Widths of the coordinate path, projection modes and the job record passed
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int CoordW     = 16;  // Q12.4 input coordinate
    localparam int DiffW      = 17;  // coordinate difference
    localparam int SumW       = 35;  // dot product and squared length
    localparam int TFracW     = 16;  // projection parameter fraction bits
    localparam int TW         = 17;  // projection parameter, 0 .. 1.0
    localparam int ProdW      = 35;  // t * delta
    localparam int ResW       = 19;  // residual vector component
    localparam int SqW        = 38;  // squared residual component
    localparam int D2W        = 36;  // squared distance
    localparam int RootW      = D2W / 2;
    localparam int RemW       = RootW + 3;
    localparam int DistW      = 17;
    localparam int RadiusW    = 15;
    localparam int InDataW    = 6 * CoordW;
    localparam int OutDataW   = 24;
    localparam int FifoDepthDefault = 4;

    localparam logic [RadiusW-1:0] RadiusReset = 15'd160;
    localparam logic [TW-1:0]      TOne        = 17'h10000;

    typedef enum logic [1:0] {
        TM_ZERO = 2'd0,  // t = 0: start point or degenerate segment
        TM_ONE  = 2'd1,  // t = 1: end point
        TM_DIV  = 2'd2   // t strictly between, from the divider
    } csd_tmode_t;

    typedef struct packed {
        csd_tmode_t              mode;
        logic signed [DiffW-1:0] px;
        logic signed [DiffW-1:0] py;
        logic signed [DiffW-1:0] dx;
        logic signed [DiffW-1:0] dy;
        logic [SumW-1:0]         dot;
        logic [SumW-1:0]         len2;
    } csd_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } csd_fifo_stat_t;

endpackage

FILE: sv/csd_front.sv
// ----------------------------------------------------------------------------
// csd_front: input stage of the distance unit
// Takes query transfers, forms offsets and products, and classifies the
// projection as start point, end point or a true division.
// ----------------------------------------------------------------------------
module csd_front
    import csd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [InDataW-1:0]   in_data,
    input  logic                 enable,
    output logic                 push,
    output csd_job_t             job
);

    logic                        v1_reg, v2_reg;
    logic signed [DiffW-1:0]     dx1_reg, dy1_reg, px1_reg, py1_reg;
    logic signed [DiffW-1:0]     dx2_reg, dy2_reg, px2_reg, py2_reg;
    logic signed [2*DiffW-1:0]   sqx_reg, sqy_reg, pdx_reg, pdy_reg;
    logic signed [CoordW-1:0]    cx, cy, sx, sy, ex, ey;
    logic signed [SumW:0]        dot_s, len2_s;

    // unpack fields, lowest first
    assign cx = in_data[0*CoordW +: CoordW];
    assign cy = in_data[1*CoordW +: CoordW];
    assign sx = in_data[2*CoordW +: CoordW];
    assign sy = in_data[3*CoordW +: CoordW];
    assign ex = in_data[4*CoordW +: CoordW];
    assign ey = in_data[5*CoordW +: CoordW];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (enable)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // offsets, then products
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            dx1_reg <= DiffW'(ex) - DiffW'(sx);
            dy1_reg <= DiffW'(ey) - DiffW'(sy);
            px1_reg <= DiffW'(cx) - DiffW'(sx);
            py1_reg <= DiffW'(cy) - DiffW'(sy);
            sqx_reg <= dx1_reg * dx1_reg;
            sqy_reg <= dy1_reg * dy1_reg;
            pdx_reg <= px1_reg * dx1_reg;
            pdy_reg <= py1_reg * dy1_reg;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
        end
    end

    // sum and classify
    assign dot_s  = (SumW+1)'(pdx_reg) + (SumW+1)'(pdy_reg);
    assign len2_s = (SumW+1)'(sqx_reg) + (SumW+1)'(sqy_reg);

    always_comb
    begin
        job.px   = px2_reg;
        job.py   = py2_reg;
        job.dx   = dx2_reg;
        job.dy   = dy2_reg;
        job.dot  = dot_s[SumW-1:0];
        job.len2 = len2_s[SumW-1:0];
        if (len2_s == '0 || dot_s <= 0)
            job.mode = TM_ZERO;
        else if (dot_s >= len2_s)
            job.mode = TM_ONE;
        else
            job.mode = TM_DIV;
    end

    assign push = v2_reg && enable;

endmodule

FILE: sv/csd_fifo.sv
// ----------------------------------------------------------------------------
// csd_fifo: job queue between front and back end
// Short register queue so each side can stall on its own.
// ----------------------------------------------------------------------------
module csd_fifo
    import csd_pkg::*;
#(
    parameter int DEPTH = FifoDepthDefault
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  csd_job_t       wr_job,
    input  logic           pop,
    output csd_job_t       rd_job,
    output csd_fifo_stat_t stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    csd_job_t              mem_reg [DEPTH];
    logic [PtrW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]       count_reg;

    assign stat.full  = (count_reg == CntW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_job     = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // store entry
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

FILE: sv/csd_back.sv
// ----------------------------------------------------------------------------
// csd_back: projection and distance pipeline
// Bit-per-stage divider for t, projected offset, squared distance and a
// two-bits-per-stage square root, ending in the output register.
// ----------------------------------------------------------------------------
module csd_back
    import csd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  csd_job_t             job,
    output logic                 pop,
    input  logic [RadiusW-1:0]   radius,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DistW-1:0]     out_distance,
    output logic                 out_hit
);

    logic enable;

    // divider stages
    logic                        dv_reg   [TFracW+1];
    csd_job_t                    dj_reg   [TFracW+1];
    logic [SumW-1:0]             drem_reg [TFracW+1];
    logic [TFracW-1:0]           dq_reg   [TFracW+1];

    // projection stages
    logic                        mv_reg, rv_reg, qv_reg, nv_reg;
    logic signed [ProdW-1:0]     mx_reg, my_reg;
    logic signed [DiffW-1:0]     mpx_reg, mpy_reg;
    logic signed [ResW-1:0]      rx_reg, ry_reg;
    logic [SqW-1:0]              qx_reg, qy_reg;
    logic [D2W-1:0]              n_reg;
    logic [TW-1:0]               t_val;
    logic signed [TW:0]          t_s;
    logic [SqW:0]                d2_sum;

    // square root stages
    logic                        sv_reg   [RootW+1];
    logic [D2W-1:0]              sn_reg   [RootW+1];
    logic [RemW-1:0]             srem_reg [RootW+1];
    logic [RootW-1:0]            sroot_reg[RootW+1];

    logic                        ov_reg, ohit_reg;
    logic [DistW-1:0]            odist_reg;

    assign enable    = !ov_reg || out_ready;
    assign pop       = enable && job_valid;
    assign out_valid = ov_reg;
    assign out_distance = odist_reg;
    assign out_hit   = ohit_reg;

    // load divider from queue head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (enable)
            dv_reg[0] <= job_valid;
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            dj_reg[0]   <= job;
            drem_reg[0] <= job.dot;
            dq_reg[0]   <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < TFracW; k++)
    begin : g_div
        logic [SumW:0] r2;
        logic [SumW:0] diff;
        assign r2   = {drem_reg[k], 1'b0};
        assign diff = r2 - {1'b0, dj_reg[k].len2};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (enable)
                dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                dj_reg[k+1] <= dj_reg[k];
                if (!diff[SumW])
                begin
                    drem_reg[k+1] <= diff[SumW-1:0];
                    dq_reg[k+1]   <= {dq_reg[k][TFracW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[k+1] <= r2[SumW-1:0];
                    dq_reg[k+1]   <= {dq_reg[k][TFracW-2:0], 1'b0};
                end
            end
        end
    end

    // pick t by projection mode
    always_comb
    begin
        unique case (dj_reg[TFracW].mode)
            TM_ONE:  t_val = TOne;
            TM_DIV:  t_val = {1'b0, dq_reg[TFracW]};
            default: t_val = '0;
        endcase
    end
    assign t_s = {1'b0, t_val};

    assign d2_sum = {1'b0, qx_reg} + {1'b0, qy_reg};

    // valid bits of the projection stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            rv_reg <= 1'b0;
            qv_reg <= 1'b0;
            nv_reg <= 1'b0;
        end
        else if (enable)
        begin
            mv_reg <= dv_reg[TFracW];
            rv_reg <= mv_reg;
            qv_reg <= rv_reg;
            nv_reg <= qv_reg;
        end
    end

    // scale delta, subtract floored offset, square, sum
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            mx_reg  <= ProdW'(t_s * dj_reg[TFracW].dx);
            my_reg  <= ProdW'(t_s * dj_reg[TFracW].dy);
            mpx_reg <= dj_reg[TFracW].px;
            mpy_reg <= dj_reg[TFracW].py;
            rx_reg  <= ResW'(mpx_reg) - ResW'(mx_reg >>> TFracW);
            ry_reg  <= ResW'(mpy_reg) - ResW'(my_reg >>> TFracW);
            qx_reg  <= SqW'(rx_reg * rx_reg);
            qy_reg  <= SqW'(ry_reg * ry_reg);
            n_reg   <= d2_sum[D2W-1:0];
        end
    end

    // load root stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg[0] <= 1'b0;
        else if (enable)
            sv_reg[0] <= nv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            sn_reg[0]    <= n_reg;
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
        end
    end

    // one root bit per stage
    for (genvar j = 0; j < RootW; j++)
    begin : g_sqrt
        logic [RemW-1:0] acc;
        logic [RemW-1:0] trial;
        assign acc   = {srem_reg[j][RemW-3:0], sn_reg[j][D2W-1 -: 2]};
        assign trial = RemW'({sroot_reg[j], 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[j+1] <= 1'b0;
            else if (enable)
                sv_reg[j+1] <= sv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                sn_reg[j+1] <= {sn_reg[j][D2W-3:0], 2'b00};
                if (acc >= trial)
                begin
                    srem_reg[j+1]  <= acc - trial;
                    sroot_reg[j+1] <= {sroot_reg[j][RootW-2:0], 1'b1};
                end
                else
                begin
                    srem_reg[j+1]  <= acc;
                    sroot_reg[j+1] <= {sroot_reg[j][RootW-2:0], 1'b0};
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (enable)
            ov_reg <= sv_reg[RootW];
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            odist_reg <= sroot_reg[RootW][DistW-1:0];
            ohit_reg  <= (sroot_reg[RootW] <= RootW'(radius));
        end
    end

endmodule

FILE: sv/circle_segment_distance_unit.sv
// ----------------------------------------------------------------------------
// circle_segment_distance_unit: circle centre to line segment distance
// Streams queries of a centre and a segment and returns the distance and a
// hit flag against the programmed radius.
// ----------------------------------------------------------------------------
// Takes one query per clock while the queue is not full and returns one
// result per query, in order. A query passes the front registers, the
// queue, a load stage and sixteen divider stages for the projection
// parameter (one quotient bit each), four projection and squaring stages,
// a load stage and eighteen square root stages (one root bit each) and the
// output register. Write circle_radius only while no query is in flight.
module circle_segment_distance_unit
    import csd_pkg::*;
#(
    parameter int FIFO_DEPTH = FifoDepthDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [RadiusW-1:0]  cfg_wr_data,   // circle_radius
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // centre_x, centre_y, start_x, start_y, end_x, end_y (16 bits each)
    input  logic [InDataW-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // distance [16:0], hit [17], zero fill [23:18]
    output logic [OutDataW-1:0] m_axis_tdata
);

    logic [RadiusW-1:0] radius_reg;
    logic               push, pop, front_en;
    csd_job_t           wr_job, rd_job;
    csd_fifo_stat_t     fstat;
    logic [DistW-1:0]   distance;
    logic               hit;

    // radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RadiusReset;
        else if (cfg_wr_en)
            radius_reg <= cfg_wr_data;
    end

    // hold the front while the queue is full
    assign front_en      = !fstat.full;
    assign s_axis_tready = front_en;

    csd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .enable   (front_en),
        .push     (push),
        .job      (wr_job)
    );

    csd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .stat   (fstat)
    );

    csd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (!fstat.empty),
        .job          (rd_job),
        .pop          (pop),
        .radius       (radius_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_distance (distance),
        .out_hit      (hit)
    );

    assign m_axis_tdata = {{(OutDataW - DistW - 1){1'b0}}, hit, distance};

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fstat.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fstat.empty)
        else $error("queue read while empty");

    a_hit_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (hit == ({1'b0, distance} <= (DistW+1)'(radius_reg))))
        else $error("hit flag disagrees with distance");

    a_full_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (fstat.full && pop) |=> !fstat.full)
        else $error("queue stayed full after a read with the front held");
`endif

endmodule
